>>> sv/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms for the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Field widths, command and status codes, and the default capacity.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

endpackage

>>> sv/ple_ram.sv
// ----------------------------------------------------------------------------
// Positional list engine RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = ple_pkg::VAL_W,
  parameter int DEPTH = ple_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with positional insert and remove,
// and a first-match search.
// ----------------------------------------------------------------------------
// The list lives in one RAM and is handled one item at a time. A single read
// port and a single write port step through the stored entries one per cycle,
// so the RAM sets the timing. An insert shifts the entries from the tail down
// to its position up by one and then writes the value; a remove shifts the
// entries above its position down by one; a find compares entries from the
// head until the first match or the end of the list. Rejected commands, the
// unused command code, a find on an empty list and removes at the tail go
// straight to the finish state, and inserts at the tail only write the value.
// The longest items are an insert at the head of a list of CAPACITY-1 entries
// and a missed find on a full list. The next item can be taken only once the
// block is back in idle, which it enters as it presents a result. The RAM
// needs no clearing after reset, since only entries below the length are ever
// read. The result sits in an output register, so one result can wait while
// the next item is taken; a second result waits in the finish state until the
// output register is free.
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ple_pkg::CMD_W-1:0]       in_cmd,
  input  logic [ple_pkg::POS_W-1:0]       in_position,
  input  logic signed [ple_pkg::VAL_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ple_pkg::STATUS_W-1:0]    out_status,
  output logic [ple_pkg::POS_W-1:0]       out_found_position,
  output logic [ple_pkg::POS_W-1:0]       out_list_length
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT_UP = 3'd1;
  localparam logic [2:0] S_SHIFT_DN = 3'd2;
  localparam logic [2:0] S_DRAIN    = 3'd3;
  localparam logic [2:0] S_INS_VAL  = 3'd4;
  localparam logic [2:0] S_SEARCH   = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           pend_r, pend_nxt;
  logic                           cmp_pend_r, cmp_pend_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           op_ins_r, op_ins_nxt;
  logic [CNT_W-1:0]               ptr_r, ptr_nxt;
  logic [CNT_W-1:0]               tgt_r, tgt_nxt;
  logic [CNT_W-1:0]               wa_r, wa_nxt;
  logic [CNT_W-1:0]               cmp_idx_r, cmp_idx_nxt;
  logic signed [ple_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [ple_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [ple_pkg::POS_W-1:0]      res_found_r, res_found_nxt;
  logic [ple_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [ple_pkg::POS_W-1:0]      out_found_r, out_found_nxt;
  logic [ple_pkg::POS_W-1:0]      out_len_r, out_len_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ple_pkg::VAL_W-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [ple_pkg::VAL_W-1:0] ram_rdata;

  logic             accept;
  logic             out_free;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  ple_ram #(
    .WIDTH(ple_pkg::VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(cnt_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    cmp_pend_nxt   = 1'b0;
    op_ins_nxt     = op_ins_r;
    ptr_nxt        = ptr_r;
    tgt_nxt        = tgt_r;
    wa_nxt         = wa_r;
    cmp_idx_nxt    = cmp_idx_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;
    out_valid_nxt  = out_valid_r && out_stall;

    // Shift writes follow their reads in the next cycle, using the registered read data.
    ram_we    = pend_r;
    ram_waddr = wa_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt        = in_value;
          res_status_nxt = ple_pkg::ST_OK;
          res_found_nxt  = '0;
          state_nxt      = S_FINISH;
          case (in_cmd)
            ple_pkg::CMD_INSERT: begin
              op_ins_nxt = 1'b1;
              if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                res_status_nxt = ple_pkg::ST_BAD_POS;
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = ple_pkg::ST_FULL;
              end else if (pos_ext - CMP_W'(1) == cnt_ext) begin
                tgt_nxt   = cnt_r;
                state_nxt = S_INS_VAL;
              end else begin
                tgt_nxt   = CNT_W'(pos_ext - CMP_W'(1));
                ptr_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_SHIFT_UP;
              end
            end
            ple_pkg::CMD_REMOVE: begin
              op_ins_nxt = 1'b0;
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                res_status_nxt = ple_pkg::ST_BAD_POS;
              end else if (pos_ext == cnt_ext) begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end else begin
                ptr_nxt   = CNT_W'(pos_ext);
                state_nxt = S_SHIFT_DN;
              end
            end
            ple_pkg::CMD_FIND: begin
              if (cnt_r == '0) begin
                res_status_nxt = ple_pkg::ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              res_status_nxt = ple_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        pend_nxt = 1'b1;
        wa_nxt   = ptr_r + CNT_W'(1);
        if (ptr_r == tgt_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r - CNT_W'(1);
        end
      end
      S_SHIFT_DN: begin
        pend_nxt = 1'b1;
        wa_nxt   = ptr_r - CNT_W'(1);
        if (ptr_r == cnt_r - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        // The last shifted entry is written back in this cycle.
        if (op_ins_r) begin
          state_nxt = S_INS_VAL;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_FINISH;
        end
      end
      S_INS_VAL: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r[AW-1:0];
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_FINISH;
      end
      S_SEARCH: begin
        if (cmp_pend_r && ram_rdata == val_r) begin
          res_status_nxt = ple_pkg::ST_OK;
          res_found_nxt  = ple_pkg::POS_W'(cmp_idx_r + CNT_W'(1));
          state_nxt      = S_FINISH;
        end else if (cmp_pend_r && cmp_idx_r == cnt_r - CNT_W'(1)) begin
          res_status_nxt = ple_pkg::ST_MISS;
          state_nxt      = S_FINISH;
        end else begin
          cmp_pend_nxt = 1'b1;
          cmp_idx_nxt  = ptr_r;
          ptr_nxt      = ptr_r + CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_len_nxt    = ple_pkg::POS_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_ins_r     <= op_ins_nxt;
    ptr_r        <= ptr_nxt;
    tgt_r        <= tgt_nxt;
    wa_r         <= wa_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_len_r;

  `PLE_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(CAPACITY),
                  "length above capacity")
  `PLE_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE,
                   "accepted item left block idle")
  `PLE_ASSERT_NOW(a_pend_state, clk, rst_n, pend_r,
                  state_r == S_SHIFT_UP || state_r == S_SHIFT_DN || state_r == S_DRAIN,
                  "shift write outside a shift")
  `PLE_ASSERT_NEXT(a_cnt_step, clk, rst_n, 1'b1,
                   cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1)
                   || cnt_r == $past(cnt_r) - CNT_W'(1),
                   "length moved by more than one")

endmodule
